>>> src/stp_pkg.sv
// Shared types and constants of the sorted timer service.
package stp_pkg;

   localparam int SLOTS  = 32;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int NOW_W  = 48;
   localparam int SEQ_W  = 32;
   localparam int IVL_W  = 32;
   localparam int NUM_W  = 31;
   localparam int TICK_W = 10;
   localparam logic [TICK_W-1:0] TICK_MIN = TICK_W'(10);

   typedef enum logic [2:0] {
      MODE_CREATE  = 3'd0,
      MODE_DELETE  = 3'd1,
      MODE_START   = 3'd2,
      MODE_STOP    = 3'd3,
      MODE_RESTART = 3'd4,
      MODE_UPDATE  = 3'd5,
      MODE_READ    = 3'd6,
      MODE_TICK    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_STATE = 2'd1,
      ST_NO_SLOT   = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      COND_FREE   = 2'd0,
      COND_IDLE   = 2'd1,
      COND_ACTIVE = 2'd2
   } cond_type;

   typedef struct packed {
      logic             rep;
      logic             ctx;
      logic [IVL_W-1:0] interval;
      logic [NOW_W-1:0] deadline;
      logic [SEQ_W-1:0] seq;
   } rec_type;

endpackage

>>> src/stp_if.sv
// Request and response channel interfaces of the sorted timer service.
interface stp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [4:0]  timer_slot;
   logic [19:0] timeout_sec;
   logic [15:0] timeout_ms;
   logic        repetitive;
   logic        separate_context;
   modport source (output valid, mode, timer_slot, timeout_sec, timeout_ms, repetitive,
                   separate_context, input ready);
   modport sink (input valid, mode, timer_slot, timeout_sec, timeout_ms, repetitive,
                 separate_context, output ready);
endinterface

interface stp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] slot_out;
   logic       fired;
   logic       fire_separate_context;
   logic       type_repetitive;
   logic       last;
   modport source (output valid, status, slot_out, fired, fire_separate_context,
                   type_repetitive, last, input ready);
   modport sink (input valid, status, slot_out, fired, fire_separate_context,
                 type_repetitive, last, output ready);
endinterface

>>> src/sorted_timer_service.sv
// Top level of the sorted timer service: command sequencer around the slot memory.
//
// req_ch carries one command beat: create, delete, start, stop, restart, update,
// read type or tick. rsp_ch returns result beats; the final beat of a command has
// last set. csr_wr_en/csr_wr_data write tick_ms; the user must write it only while
// the block is idle, which the block itself does not enforce. One command is
// handled at a time; req_ch.ready is high only between commands. Delete, start,
// stop, restart and read type read the slot memory and execute before the response
// handshake. Create and update first wait for the interval divider. A tick scans
// the 32-entry slot memory once per fired timer, plus once more when fewer than 32
// fire, with at most 32 fires. Each pass is bounded by one memory read per cycle.
// At reset all slots are free, the tick count and start sequence are zero and
// tick_ms is 10. A response beat holds in its register until rsp_ch.ready; the
// sequencer waits there, so a stalled receiver stalls the block.
module sorted_timer_service (
   input  logic                        clock,
   input  logic                        reset,
   stp_req_if.sink                     req_ch,
   stp_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [stp_pkg::TICK_W-1:0]  csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_RD, S_EXEC, S_CREATE, S_TSTART, S_SCAN, S_FIRE, S_FLUSH, S_WAIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   stp_pkg::rec_type mem [stp_pkg::SLOTS];
   stp_pkg::rec_type mem_rd_ff;
   logic                       mem_we;
   logic [stp_pkg::SLOT_W-1:0] mem_wa, mem_ra;
   stp_pkg::rec_type           mem_wd;

   logic [2:0]                  mode_ff, mode_in;
   logic [stp_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic                        rep_ff, rep_in, ctx_ff, ctx_in;
   logic [stp_pkg::TICK_W-1:0]  tick_ff;
   stp_pkg::cond_type           cond_ff [stp_pkg::SLOTS];
   stp_pkg::cond_type           cond_in [stp_pkg::SLOTS];
   logic [stp_pkg::NOW_W-1:0]   now_ff, now_in;
   logic [stp_pkg::SEQ_W-1:0]   seq_ff, seq_in;
   logic [stp_pkg::SLOTS-1:0]   done_ff, done_in;
   logic [stp_pkg::SLOT_W:0]    nfire_ff, nfire_in;
   logic [stp_pkg::SLOT_W:0]    scan_ff, scan_in;
   logic                        rdv_ff, rdv_in;
   logic [stp_pkg::SLOT_W-1:0]  rdi_ff, rdi_in;
   logic                        bestv_ff, bestv_in;
   logic [stp_pkg::SLOT_W-1:0]  besti_ff, besti_in;
   stp_pkg::rec_type            best_ff, best_in;
   logic                        pendv_ff, pendv_in;
   logic [stp_pkg::SLOT_W-1:0]  pslot_ff, pslot_in;
   logic                        pctx_ff, pctx_in, prep_ff, prep_in;
   logic                        ov_ff, ov_in;
   stp_pkg::status_type         ost_ff, ost_in;
   logic [stp_pkg::SLOT_W-1:0]  oslot_ff, oslot_in;
   logic                        ofired_ff, ofired_in, octx_ff, octx_in;
   logic                        orep_ff, orep_in, olast_ff, olast_in;

   logic                        div_start, div_busy;
   logic [stp_pkg::NUM_W-1:0]   div_num, div_q;
   logic [stp_pkg::TICK_W-1:0]  div_den;
   logic [stp_pkg::IVL_W-1:0]   new_ivl;
   logic                        free_found;
   logic [stp_pkg::SLOT_W-1:0]  free_idx;
   logic                        cand, better;
   logic [stp_pkg::SEQ_W-1:0]   age_c, age_b;
   logic [stp_pkg::SLOT_W:0]    nfire_nx;
   stp_pkg::cond_type           cur_cond;
   logic [stp_pkg::NUM_W-1:0]   sec_w;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.status = ost_ff;
   assign rsp_ch.slot_out = oslot_ff;
   assign rsp_ch.fired = ofired_ff;
   assign rsp_ch.fire_separate_context = octx_ff;
   assign rsp_ch.type_repetitive = orep_ff;
   assign rsp_ch.last = olast_ff;

   assign sec_w = stp_pkg::NUM_W'(req_ch.timeout_sec);
   assign div_num = (sec_w << 10) - (sec_w << 4) - (sec_w << 3)
                    + stp_pkg::NUM_W'(req_ch.timeout_ms);
   assign div_den = (tick_ff < stp_pkg::TICK_MIN) ? stp_pkg::TICK_MIN : tick_ff;
   assign new_ivl = stp_pkg::IVL_W'(div_q);
   assign cur_cond = cond_ff[slot_ff];
   assign nfire_nx = nfire_ff + 1'b1;

   stp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_q)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = stp_pkg::SLOTS - 1; i >= 0; i--) begin
         if (cond_ff[i] == stp_pkg::COND_FREE) begin
            free_found = 1'b1;
            free_idx = stp_pkg::SLOT_W'(i);
         end
      end
   end

   assign age_c = seq_ff - mem_rd_ff.seq;
   assign age_b = seq_ff - best_ff.seq;
   assign cand = rdv_ff && !done_ff[rdi_ff] && (cond_ff[rdi_ff] == stp_pkg::COND_ACTIVE)
                 && (mem_rd_ff.deadline <= now_ff);
   assign better = !bestv_ff || (mem_rd_ff.deadline < best_ff.deadline)
                   || ((mem_rd_ff.deadline == best_ff.deadline) && (age_c > age_b));

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      mode_in = mode_ff;
      slot_in = slot_ff;
      rep_in = rep_ff;
      ctx_in = ctx_ff;
      cond_in = cond_ff;
      now_in = now_ff;
      seq_in = seq_ff;
      done_in = done_ff;
      nfire_in = nfire_ff;
      scan_in = scan_ff;
      rdv_in = 1'b0;
      rdi_in = rdi_ff;
      bestv_in = bestv_ff;
      besti_in = besti_ff;
      best_in = best_ff;
      pendv_in = pendv_ff;
      pslot_in = pslot_ff;
      pctx_in = pctx_ff;
      prep_in = prep_ff;
      ov_in = ov_ff;
      ost_in = ost_ff;
      oslot_in = oslot_ff;
      ofired_in = ofired_ff;
      octx_in = octx_ff;
      orep_in = orep_ff;
      olast_in = olast_ff;
      div_start = 1'b0;
      mem_we = 1'b0;
      mem_wa = slot_ff;
      mem_wd = mem_rd_ff;
      mem_ra = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               slot_in = req_ch.timer_slot;
               rep_in = req_ch.repetitive;
               ctx_in = req_ch.separate_context;
               unique case (stp_pkg::mode_type'(req_ch.mode))
                  stp_pkg::MODE_TICK: state_in = S_TSTART;
                  stp_pkg::MODE_CREATE, stp_pkg::MODE_UPDATE: begin
                     div_start = 1'b1;
                     state_in = S_DIV;
                  end
                  default: state_in = S_RD;
               endcase
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = (mode_ff == stp_pkg::MODE_CREATE) ? S_CREATE : S_RD;
            end
         end
         S_RD: begin
            state_in = S_EXEC;
         end
         S_CREATE: begin
            ov_in = 1'b1;
            ofired_in = 1'b0;
            octx_in = 1'b0;
            olast_in = 1'b1;
            state_in = S_WAIT;
            ret_in = S_IDLE;
            if (free_found) begin
               cond_in[free_idx] = stp_pkg::COND_IDLE;
               mem_we = 1'b1;
               mem_wa = free_idx;
               mem_wd = '{rep: rep_ff, ctx: ctx_ff, interval: new_ivl,
                          deadline: '0, seq: '0};
               ost_in = stp_pkg::ST_OK;
               oslot_in = free_idx;
               orep_in = rep_ff;
            end else begin
               ost_in = stp_pkg::ST_NO_SLOT;
               oslot_in = '0;
               orep_in = 1'b0;
            end
         end
         S_EXEC: begin
            ov_in = 1'b1;
            ost_in = stp_pkg::ST_OK;
            oslot_in = slot_ff;
            ofired_in = 1'b0;
            octx_in = 1'b0;
            orep_in = mem_rd_ff.rep;
            olast_in = 1'b1;
            state_in = S_WAIT;
            ret_in = S_IDLE;
            mem_wd = mem_rd_ff;
            mem_wd.deadline = now_ff + stp_pkg::NOW_W'(mem_rd_ff.interval);
            mem_wd.seq = seq_ff;
            unique case (stp_pkg::mode_type'(mode_ff))
               stp_pkg::MODE_DELETE: begin
                  if (cur_cond == stp_pkg::COND_FREE) ost_in = stp_pkg::ST_BAD_STATE;
                  else cond_in[slot_ff] = stp_pkg::COND_FREE;
               end
               stp_pkg::MODE_START: begin
                  if (cur_cond != stp_pkg::COND_IDLE) begin
                     ost_in = stp_pkg::ST_BAD_STATE;
                  end else begin
                     cond_in[slot_ff] = stp_pkg::COND_ACTIVE;
                     mem_we = 1'b1;
                     seq_in = seq_ff + 1'b1;
                  end
               end
               stp_pkg::MODE_STOP: begin
                  if (cur_cond == stp_pkg::COND_FREE) ost_in = stp_pkg::ST_BAD_STATE;
                  else cond_in[slot_ff] = stp_pkg::COND_IDLE;
               end
               stp_pkg::MODE_RESTART: begin
                  if (cur_cond == stp_pkg::COND_FREE) begin
                     ost_in = stp_pkg::ST_BAD_STATE;
                  end else begin
                     cond_in[slot_ff] = stp_pkg::COND_ACTIVE;
                     mem_we = 1'b1;
                     seq_in = seq_ff + 1'b1;
                  end
               end
               stp_pkg::MODE_UPDATE: begin
                  if (cur_cond == stp_pkg::COND_FREE) begin
                     ost_in = stp_pkg::ST_BAD_HANDLE;
                  end else begin
                     mem_we = 1'b1;
                     mem_wd.interval = new_ivl;
                     if (cur_cond == stp_pkg::COND_ACTIVE) begin
                        mem_wd.deadline = now_ff + stp_pkg::NOW_W'(new_ivl);
                        seq_in = seq_ff + 1'b1;
                     end else begin
                        mem_wd.deadline = mem_rd_ff.deadline;
                        mem_wd.seq = mem_rd_ff.seq;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_TSTART: begin
            now_in = now_ff + 1'b1;
            done_in = '0;
            nfire_in = '0;
            pendv_in = 1'b0;
            scan_in = '0;
            bestv_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            mem_ra = scan_ff[stp_pkg::SLOT_W-1:0];
            if (scan_ff < stp_pkg::SLOTS) begin
               scan_in = scan_ff + 1'b1;
               rdv_in = 1'b1;
               rdi_in = scan_ff[stp_pkg::SLOT_W-1:0];
            end
            if (cand && better) begin
               bestv_in = 1'b1;
               besti_in = rdi_ff;
               best_in = mem_rd_ff;
            end
            if (rdv_ff && (rdi_ff == stp_pkg::SLOT_W'(stp_pkg::SLOTS - 1))) begin
               state_in = S_FIRE;
            end
         end
         S_FIRE: begin
            scan_in = '0;
            bestv_in = 1'b0;
            if (bestv_ff) begin
               done_in[besti_ff] = 1'b1;
               nfire_in = nfire_nx;
               if (best_ff.rep) begin
                  cond_in[besti_ff] = stp_pkg::COND_ACTIVE;
                  mem_we = 1'b1;
                  mem_wa = besti_ff;
                  mem_wd = best_ff;
                  mem_wd.deadline = now_ff + stp_pkg::NOW_W'(best_ff.interval);
                  mem_wd.seq = seq_ff;
                  seq_in = seq_ff + 1'b1;
               end else begin
                  cond_in[besti_ff] = stp_pkg::COND_IDLE;
               end
               pendv_in = 1'b1;
               pslot_in = besti_ff;
               pctx_in = best_ff.ctx;
               prep_in = best_ff.rep;
               ret_in = (nfire_nx == stp_pkg::SLOTS) ? S_FLUSH : S_SCAN;
               if (pendv_ff) begin
                  ov_in = 1'b1;
                  ost_in = stp_pkg::ST_OK;
                  oslot_in = pslot_ff;
                  ofired_in = 1'b1;
                  octx_in = pctx_ff;
                  orep_in = prep_ff;
                  olast_in = 1'b0;
                  state_in = S_WAIT;
               end else begin
                  state_in = ret_in;
               end
            end else begin
               ov_in = 1'b1;
               ost_in = stp_pkg::ST_OK;
               oslot_in = pendv_ff ? pslot_ff : '0;
               ofired_in = pendv_ff;
               octx_in = pendv_ff & pctx_ff;
               orep_in = pendv_ff & prep_ff;
               olast_in = 1'b1;
               pendv_in = 1'b0;
               state_in = S_WAIT;
               ret_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            ov_in = 1'b1;
            ost_in = stp_pkg::ST_OK;
            oslot_in = pslot_ff;
            ofired_in = 1'b1;
            octx_in = pctx_ff;
            orep_in = prep_ff;
            olast_in = 1'b1;
            pendv_in = 1'b0;
            state_in = S_WAIT;
            ret_in = S_IDLE;
         end
         S_WAIT: begin
            if (rsp_ch.ready) begin
               ov_in = 1'b0;
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         tick_ff <= stp_pkg::TICK_MIN;
         for (int i = 0; i < stp_pkg::SLOTS; i++) cond_ff[i] <= stp_pkg::COND_FREE;
         now_ff <= '0;
         seq_ff <= '0;
         ov_ff <= 1'b0;
         rdv_ff <= 1'b0;
         pendv_ff <= 1'b0;
         bestv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         if (csr_wr_en) tick_ff <= csr_wr_data;
         cond_ff <= cond_in;
         now_ff <= now_in;
         seq_ff <= seq_in;
         ov_ff <= ov_in;
         rdv_ff <= rdv_in;
         pendv_ff <= pendv_in;
         bestv_ff <= bestv_in;
      end
      mode_ff <= mode_in;
      slot_ff <= slot_in;
      rep_ff <= rep_in;
      ctx_ff <= ctx_in;
      done_ff <= done_in;
      nfire_ff <= nfire_in;
      scan_ff <= scan_in;
      rdi_ff <= rdi_in;
      besti_ff <= besti_in;
      best_ff <= best_in;
      pslot_ff <= pslot_in;
      pctx_ff <= pctx_in;
      prep_ff <= prep_in;
      ost_ff <= ost_in;
      oslot_ff <= oslot_in;
      ofired_ff <= ofired_in;
      octx_ff <= octx_in;
      orep_ff <= orep_in;
      olast_ff <= olast_in;
   end

endmodule

>>> src/stp_div.sv
// Bit-serial restoring divider for the timer interval in ticks.
module stp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [stp_pkg::NUM_W-1:0]     num,
   input  logic [stp_pkg::TICK_W-1:0]    den,
   output logic                          busy,
   output logic [stp_pkg::NUM_W-1:0]     quot
);

   logic [stp_pkg::TICK_W-1:0] rem_ff, rem_in;
   logic [stp_pkg::NUM_W-1:0]  quo_ff, quo_in;
   logic [stp_pkg::TICK_W-1:0] den_ff, den_in;
   logic [$clog2(stp_pkg::NUM_W+1)-1:0] cnt_ff, cnt_in;
   logic [stp_pkg::TICK_W:0]   trial;

   assign busy = (cnt_ff != '0);
   assign quot = quo_ff;
   assign trial = {rem_ff, quo_ff[stp_pkg::NUM_W-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = ($clog2(stp_pkg::NUM_W+1))'(stp_pkg::NUM_W);
      end else if (busy) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = stp_pkg::TICK_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[stp_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[stp_pkg::TICK_W-1:0];
            quo_in = {quo_ff[stp_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule
